// ===== design/cbdf_pkg.sv =====
// Package for the console byte and decimal formatter.
// Holds widths, byte codes, item and job structs and state types.
// Depends on nothing; every other file of the block imports it.
package cbdf_pkg;

  localparam int NUMBER_WIDTH  = 32;
  localparam int NUM_DIGITS    = (NUMBER_WIDTH * 301) / 1000 + 1;
  localparam int DIGIT_IDX_W   = $clog2(NUM_DIGITS);
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = (NUMBER_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int CONV_W        = CONV_STEPS * BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_MINUS = 8'h2D;

  localparam logic CMD_CHAR   = 1'b0;
  localparam logic CMD_NUMBER = 1'b1;

  localparam logic [1:0] ERASE_FIRST = 2'd0;
  localparam logic [1:0] ERASE_MID   = 2'd1;
  localparam logic [1:0] ERASE_LAST  = 2'd2;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_ERASE,
    KIND_NUMBER
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_FIND,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic                           command;
    logic [7:0]                     char_code;
    logic signed [NUMBER_WIDTH-1:0] number;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              char_code;
    logic                    negative;
    logic [NUMBER_WIDTH-1:0] magnitude;
  } job_t;

endpackage

// ===== design/cbdf_front.sv =====
// Front end: classifies each accepted item into a job for the back end.
// Takes sign and magnitude of integers. Depends on cbdf_pkg.
module cbdf_front (
  input  cbdf_pkg::in_item_t item,
  input  logic               push,
  input  logic               q_full,
  output logic               q_write,
  output cbdf_pkg::job_t     q_job
);
  import cbdf_pkg::*;

  logic negative;

  assign negative = item.number[NUMBER_WIDTH-1];
  assign q_write  = push && !q_full;

  always_comb begin
    q_job.char_code = item.char_code;
    q_job.negative  = negative;
    q_job.magnitude = negative ? (~item.number + 1'b1) : item.number;
    if (item.command == CMD_NUMBER) begin
      q_job.kind = KIND_NUMBER;
    end else if (item.char_code == BYTE_BS || item.char_code == BYTE_DEL) begin
      q_job.kind = KIND_ERASE;
    end else begin
      q_job.kind = KIND_CHAR;
    end
  end

endmodule

// ===== design/cbdf_queue.sv =====
// Short job queue between front and back end.
// Register array with read and write pointers. Depends on cbdf_pkg.
module cbdf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           write,
  input  cbdf_pkg::job_t wdata,
  input  logic           read,
  output logic           full,
  output logic           empty,
  output cbdf_pkg::job_t head
);
  import cbdf_pkg::*;

  job_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_write;
  logic                   do_read;

  localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign head     = slots[rd_ptr];
  assign do_write = write && !full;
  assign do_read  = read && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_read) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_write && !do_read) begin
        count <= count + 1'b1;
      end else if (do_read && !do_write) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== design/cbdf_back.sv =====
// Back end: runs each job, converts magnitudes to BCD four bits a cycle
// and emits bytes into the result register. Depends on cbdf_pkg.
module cbdf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  cbdf_pkg::job_t      q_head,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output cbdf_pkg::out_item_t result
);
  import cbdf_pkg::*;

  localparam int ACC_W = NUM_DIGITS * 4 + CONV_W;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CONV_STEPS - 1);

  back_state_t                  state;
  back_state_t                  state_next;
  job_t                         job;
  logic [CONV_W-1:0]            shreg;
  logic [NUM_DIGITS-1:0][3:0]   bcd;
  logic [STEP_W-1:0]            step;
  logic [DIGIT_IDX_W-1:0]       idx;
  logic [1:0]                   pos;
  logic                         minus_done;
  logic                         out_valid;
  out_item_t                    out_item;
  out_item_t                    emit;
  logic                         emit_fire;
  logic [ACC_W-1:0]             dabble_out;

  function automatic logic [ACC_W-1:0] dabble(input logic [ACC_W-1:0] acc_in);
    logic [ACC_W-1:0] acc;
    acc = acc_in;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (acc[CONV_W + 4*d +: 4] >= 4'd5) begin
          acc[CONV_W + 4*d +: 4] = acc[CONV_W + 4*d +: 4] + 4'd3;
        end
      end
      acc = acc << 1;
    end
    return acc;
  endfunction

  function automatic logic [DIGIT_IDX_W-1:0] top_digit(
    input logic [NUM_DIGITS-1:0][3:0] v
  );
    logic [DIGIT_IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (v[i] != 4'd0) begin
        r = DIGIT_IDX_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic digits_valid(input logic [NUM_DIGITS-1:0][3:0] v);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (v[i] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign dabble_out = dabble({bcd, shreg});
  assign emit_fire  = (state == B_EMIT) && (!out_valid || pop);
  assign empty      = !out_valid;
  assign result     = out_item;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = (q_head.kind == KIND_NUMBER) ? B_CONV : B_EMIT;
        end
      end
      B_CONV: begin
        if (step == STEP_LAST) begin
          state_next = B_FIND;
        end
      end
      B_FIND: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (emit_fire && emit.last) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop         = (state == B_IDLE) && !q_empty;
    emit.out_byte = job.char_code;
    emit.last     = 1'b1;
    unique case (job.kind)
      KIND_CHAR: begin
        emit.out_byte = job.char_code;
        emit.last     = 1'b1;
      end
      KIND_ERASE: begin
        emit.out_byte = (pos == ERASE_MID) ? BYTE_SPACE : BYTE_BS;
        emit.last     = (pos == ERASE_LAST);
      end
      KIND_NUMBER: begin
        if (job.negative && !minus_done) begin
          emit.out_byte = BYTE_MINUS;
          emit.last     = 1'b0;
        end else begin
          emit.out_byte = BYTE_ZERO | {4'b0000, bcd[idx]};
          emit.last     = (idx == '0);
        end
      end
      default: begin
        emit.out_byte = job.char_code;
        emit.last     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job        <= q_head;
      shreg      <= CONV_W'(q_head.magnitude);
      bcd        <= '0;
      step       <= '0;
      pos        <= ERASE_FIRST;
      minus_done <= 1'b0;
    end
    if (state == B_CONV) begin
      {bcd, shreg} <= dabble_out;
      step         <= step + 1'b1;
    end
    if (state == B_FIND) begin
      idx <= top_digit(bcd);
    end
    if (emit_fire) begin
      out_item <= emit;
      pos      <= pos + 1'b1;
      if (job.kind == KIND_NUMBER) begin
        if (job.negative && !minus_done) begin
          minus_done <= 1'b1;
        end else begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

  a_conv_done: assert property (@(posedge clk) disable iff (rst)
    (state == B_CONV && step == STEP_LAST) |=> (state == B_FIND))
    else $error("conversion did not finish after its last step");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    (state == B_FIND) |-> digits_valid(bcd))
    else $error("BCD digit out of range after conversion");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != B_IDLE))
    else $error("job taken from queue but back end stayed idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && emit.last) |=> (state == B_IDLE && out_valid && out_item.last))
    else $error("final byte did not end the job");

endmodule

// ===== design/console_byte_and_decimal_formatter.sv =====
// Top level of the console byte and decimal formatter.
// Joins cbdf_front, cbdf_queue and cbdf_back. Depends on cbdf_pkg.
//
//   channel   handshake       payload
//   input     push / full     item   (command, char_code, number)
//   result    pop / empty     result (out_byte, last)
//
// A character job emits one byte and an erase run emits three.
// An integer job converts its magnitude to BCD in CONV_STEPS steps of 4 bits
// each for 32 bits, then emits up to 11 bytes.
// Bytes leave through the one-byte result register.
// A two-job queue keeps input taking items while results stall.
// Reset (rst, synchronous) empties queue and result register.
module console_byte_and_decimal_formatter (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  cbdf_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output cbdf_pkg::out_item_t result
);
  import cbdf_pkg::*;

  logic q_write;
  logic q_full;
  logic q_empty;
  logic q_pop;
  job_t q_job;
  job_t q_head;

  assign full = q_full;

  cbdf_front u_front (
    .item    (item),
    .push    (push),
    .q_full  (q_full),
    .q_write (q_write),
    .q_job   (q_job)
  );

  cbdf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .write (q_write),
    .wdata (q_job),
    .read  (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  cbdf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== tb/sv/console_byte_and_decimal_formatter_tb.sv =====
// Self-checking testbench for console_byte_and_decimal_formatter.
// Predicts the console byte run of each accepted command and checks every result transfer.
// Depends on cbdf_pkg and the formatter RTL.
module console_byte_and_decimal_formatter_tb;
  import cbdf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;

  out_item_t expected_bytes[$];
  int        error_count = 0;
  int        send_mode = 1;
  int        pop_mode = 1;
  int        pop_hold = 0;
  int        quiet_cycles = 0;

  console_byte_and_decimal_formatter u_top (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: return 0;
      1: begin
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
      end
      default: begin
        if (r < 30) return 0;
        if (r < 70) return $urandom_range(1, 5);
        return $urandom_range(20, 60);
      end
    endcase
  endfunction

  function automatic in_item_t make_item(logic cmd, logic [7:0] ch,
                                         logic [NUMBER_WIDTH-1:0] num);
    in_item_t it;
    it.command   = cmd;
    it.char_code = ch;
    it.number    = num;
    return it;
  endfunction

  function automatic void add_byte(logic [7:0] b, logic is_last);
    out_item_t o;
    o.out_byte = b;
    o.last     = is_last;
    expected_bytes.push_back(o);
  endfunction

  function automatic void predict_console_run(in_item_t it);
    logic [NUMBER_WIDTH-1:0] raw;
    logic [NUMBER_WIDTH-1:0] mag;
    logic [7:0]              digits[24];
    int                      nd;
    if (it.command == CMD_CHAR) begin
      if (it.char_code == BYTE_BS || it.char_code == BYTE_DEL) begin
        add_byte(BYTE_BS, 1'b0);
        add_byte(BYTE_SPACE, 1'b0);
        add_byte(BYTE_BS, 1'b1);
      end else begin
        add_byte(it.char_code, 1'b1);
      end
    end else begin
      raw = it.number;
      mag = raw[NUMBER_WIDTH-1] ? (~raw + 1'b1) : raw;
      nd  = 0;
      do begin
        digits[nd] = BYTE_ZERO + 8'(mag % 10);
        nd++;
        mag = mag / 10;
      end while (mag != 0);
      if (raw[NUMBER_WIDTH-1]) add_byte(BYTE_MINUS, 1'b0);
      for (int i = nd - 1; i >= 0; i--) add_byte(digits[i], i == 0);
    end
  endfunction

  function automatic logic [NUMBER_WIDTH-1:0] random_number();
    logic [NUMBER_WIDTH-1:0] v;
    int                      p;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: begin
        p = $urandom_range(0, 9);
        v = 1;
        repeat (p) v = v * 10;
        v = v + $urandom_range(0, 2) - 1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = {1'b0, {(NUMBER_WIDTH-1){1'b1}}};
          2: v = {1'b1, {(NUMBER_WIDTH-1){1'b0}}};
          default: v = '1;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) && v[NUMBER_WIDTH-1] == 1'b0) v = ~v + 1'b1;
    return v;
  endfunction

  function automatic in_item_t random_item();
    logic [7:0] ch;
    ch = 8'($urandom);
    if ($urandom_range(0, 9) == 0) ch = $urandom_range(0, 1) ? BYTE_BS : BYTE_DEL;
    return make_item(1'($urandom_range(0, 1)), ch, random_number());
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap(send_mode);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    predict_console_run(it);
  endtask

  task automatic test_char_extremes();
    logic [7:0] chars[10] = '{8'h00, 8'hFF, BYTE_BS, BYTE_DEL, 8'h41, 8'h07,
                              8'h09, 8'h7E, 8'h80, 8'h09};
    foreach (chars[i]) send_item(make_item(CMD_CHAR, chars[i], $urandom));
  endtask

  task automatic test_number_extremes();
    logic [NUMBER_WIDTH-1:0] nums[12] = '{0, 1, -1, 9, 10, -10, 99, 1000000000,
                                          -999999999, 32'h7FFFFFFF, 32'h80000000,
                                          123456789};
    foreach (nums[i]) send_item(make_item(CMD_NUMBER, 8'($urandom), nums[i]));
  endtask

  task automatic test_random_traffic(int count);
    send_mode = 1;
    pop_mode  = 1;
    repeat (count) send_item(random_item());
  endtask

  task automatic test_back_to_back(int count);
    send_mode = 0;
    pop_mode  = 0;
    repeat (count) send_item(random_item());
  endtask

  task automatic test_stalled_results(int count);
    send_mode = 0;
    pop_mode  = 2;
    repeat (count) send_item(random_item());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_hold = 0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      pop_hold = pick_gap(pop_mode);
      pop <= (pop_hold == 0);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result transfer: out_byte %h last %b",
               result.out_byte, result.last);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (result.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h actual %h", want.out_byte, result.out_byte);
          error_count++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %b actual %b", want.last, result.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("console_byte_and_decimal_formatter_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_char_extremes();
    test_number_extremes();
    test_random_traffic(300);
    test_back_to_back(60);
    test_stalled_results(60);
    push <= 1'b0;
    pop_mode = 1;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("console_byte_and_decimal_formatter_tb: clean");
    end else begin
      $display("console_byte_and_decimal_formatter_tb: errors");
    end
    $finish;
  end

endmodule

// ===== console_byte_and_decimal_formatter.f =====
design/cbdf_pkg.sv
design/cbdf_front.sv
design/cbdf_queue.sv
design/cbdf_back.sv
design/console_byte_and_decimal_formatter.sv
tb/sv/console_byte_and_decimal_formatter_tb.sv
